/* rtl/core/sensor_curve_pwm_with_hysteresis_macros.svh */
// Assertion macros shared by the sensor curve block.
`ifndef SENSOR_CURVE_PWM_WITH_HYSTERESIS_MACROS_SVH
`define SENSOR_CURVE_PWM_WITH_HYSTERESIS_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define SCPWM_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("scpwm assertion failed");

// Check that cons holds in the cycle after ante.
`define SCPWM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("scpwm assertion failed");

`endif

/* rtl/core/scpwm_pkg.sv */
// Shared constants, curve tables and controller interface types for the sensor curve block.
`timescale 1ns / 1ps
`default_nettype none

package scpwm_pkg;

    localparam int SAMPLE_W       = 12;
    localparam int DUTY_W         = 10;
    localparam int TABLE_LEN      = 8;
    localparam int IDX_W          = $clog2(TABLE_LEN);
    localparam int NUM_POINTS_DEF = 8;
    localparam int NUM_W          = SAMPLE_W + DUTY_W;
    localparam int DIV_STEPS      = DUTY_W;
    localparam int S_TDATA_W      = 16;
    localparam int M_TDATA_W      = 16;
    localparam int CFG_ADDR_W     = 1;
    localparam int CFG_DATA_W     = DUTY_W;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_FULL_ON  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_FULL_OFF = 1'b1;

    localparam logic [DUTY_W-1:0] FULL_ON_RST  = 10'd0;
    localparam logic [DUTY_W-1:0] FULL_OFF_RST = 10'd3;

    // Breakpoint sample positions, rising
    function automatic logic [SAMPLE_W-1:0] curve_x(input logic [IDX_W-1:0] idx);
        logic [SAMPLE_W-1:0] v;
        unique case (idx)
            3'd0: v = 12'd1250;
            3'd1: v = 12'd1293;
            3'd2: v = 12'd1586;
            3'd3: v = 12'd1879;
            3'd4: v = 12'd2171;
            3'd5: v = 12'd2464;
            3'd6: v = 12'd2757;
            default: v = 12'd3500;
        endcase
        return v;
    endfunction

    // Breakpoint duties, falling
    function automatic logic [DUTY_W-1:0] curve_y(input logic [IDX_W-1:0] idx);
        logic [DUTY_W-1:0] v;
        unique case (idx)
            3'd0: v = 10'd1023;
            3'd1: v = 10'd877;
            3'd2: v = 10'd731;
            3'd3: v = 10'd585;
            3'd4: v = 10'd438;
            3'd5: v = 10'd292;
            3'd6: v = 10'd146;
            default: v = 10'd0;
        endcase
        return v;
    endfunction

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic seg;
        logic mul0;
        logic mul1;
        logic div_step;
        logic finish;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic              direct;
        logic              out_busy;
        logic [DUTY_W-1:0] on_level;
        logic [DUTY_W-1:0] off_level;
    } dp_status_t;

endpackage

`default_nettype wire

/* rtl/core/scpwm_datapath.sv */
// Segment select, multiply, restoring divide, hysteresis flag and output register.
`timescale 1ns / 1ps
`default_nettype none

module scpwm_datapath #(
    parameter int NUM_POINTS = scpwm_pkg::NUM_POINTS_DEF
) (
    input  wire                                    aclk,
    input  wire                                    aresetn,
    input  wire scpwm_pkg::dp_cmd_t                cmd,
    output scpwm_pkg::dp_status_t                  status,
    input  wire [scpwm_pkg::SAMPLE_W-1:0]          sample_in,
    input  wire                                    cfg_wr_en,
    input  wire [scpwm_pkg::CFG_ADDR_W-1:0]        cfg_wr_addr,
    input  wire [scpwm_pkg::CFG_DATA_W-1:0]        cfg_wr_data,
    input  wire                                    m_tready,
    output logic                                   m_tvalid,
    output logic [scpwm_pkg::DUTY_W-1:0]           duty_out,
    output logic                                   flag_out
);

    localparam int NPTS = (NUM_POINTS > scpwm_pkg::TABLE_LEN) ? scpwm_pkg::TABLE_LEN :
                          ((NUM_POINTS < 2) ? 2 : NUM_POINTS);
    localparam logic [scpwm_pkg::IDX_W-1:0] IDX_LAST = scpwm_pkg::IDX_W'(NPTS - 1);
    localparam int SW = scpwm_pkg::SAMPLE_W;
    localparam int DW = scpwm_pkg::DUTY_W;
    localparam int NW = scpwm_pkg::NUM_W;

    logic [SW-1:0] x_reg, x_next;
    logic [SW-1:0] x0_reg, x0_next, x1_reg, x1_next;
    logic [DW-1:0] y0_reg, y0_next, y1_reg, y1_next;
    logic [NW-1:0] num_reg, num_next, dvs_reg, dvs_next;
    logic [DW-1:0] q_reg, q_next;
    logic [DW-1:0] on_reg, off_reg;
    logic          flag_reg, flag_next;
    logic          valid_reg, valid_next;
    logic [DW-1:0] duty_reg, duty_next;

    logic [scpwm_pkg::IDX_W-1:0] pos;
    logic [SW-1:0]               bx0, bx1;
    logic                        direct;
    logic [DW-1:0]               direct_val;
    logic [NW-1:0]               prod;

    // Find segment: count inner breakpoints strictly below the sample
    always_comb begin
        pos = scpwm_pkg::IDX_W'(1);
        for (int i = 1; i < NPTS - 1; i++) begin
            if (x_reg > scpwm_pkg::curve_x(scpwm_pkg::IDX_W'(i))) begin
                pos = pos + scpwm_pkg::IDX_W'(1);
            end
        end
        bx0 = scpwm_pkg::curve_x(pos - scpwm_pkg::IDX_W'(1));
        bx1 = scpwm_pkg::curve_x(pos);
    end

    // Clamp ends, exact breakpoint hits and flat segments bypass the divider
    always_comb begin
        direct     = 1'b0;
        direct_val = scpwm_pkg::curve_y(pos);
        if (x_reg <= scpwm_pkg::curve_x('0)) begin
            direct     = 1'b1;
            direct_val = scpwm_pkg::curve_y('0);
        end else if (x_reg >= scpwm_pkg::curve_x(IDX_LAST)) begin
            direct     = 1'b1;
            direct_val = scpwm_pkg::curve_y(IDX_LAST);
        end else if (x_reg == bx1 || bx1 <= bx0) begin
            direct     = 1'b1;
        end
    end

    // One multiplier, shared by both weight products
    always_comb begin
        if (cmd.mul0) begin
            prod = NW'(y0_reg) * NW'(x1_reg - x_reg);
        end else begin
            prod = NW'(y1_reg) * NW'(x_reg - x0_reg);
        end
    end

    // Datapath next values
    always_comb begin
        x_next    = x_reg;
        x0_next   = x0_reg;
        x1_next   = x1_reg;
        y0_next   = y0_reg;
        y1_next   = y1_reg;
        num_next  = num_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        if (cmd.load) begin
            x_next = sample_in;
        end
        if (cmd.seg) begin
            x0_next = bx0;
            x1_next = bx1;
            y0_next = scpwm_pkg::curve_y(pos - scpwm_pkg::IDX_W'(1));
            y1_next = scpwm_pkg::curve_y(pos);
            q_next  = direct_val;
        end
        if (cmd.mul0) begin
            num_next = prod;
            dvs_next = NW'(x1_reg - x0_reg) << (DW - 1);
        end
        if (cmd.mul1) begin
            num_next = num_reg + prod;
        end
        // One quotient bit per step, divisor walks right
        if (cmd.div_step) begin
            if (num_reg >= dvs_reg) begin
                num_next = num_reg - dvs_reg;
                q_next   = {q_reg[DW-2:0], 1'b1};
            end else begin
                q_next   = {q_reg[DW-2:0], 1'b0};
            end
            dvs_next = dvs_reg >> 1;
        end
    end

    // Hysteresis: clear wins over set
    always_comb begin
        flag_next = flag_reg;
        if (cmd.finish) begin
            if (q_reg > off_reg) begin
                flag_next = 1'b0;
            end else if (q_reg <= on_reg) begin
                flag_next = 1'b1;
            end
        end
    end

    // Output register
    always_comb begin
        valid_next = valid_reg;
        duty_next  = duty_reg;
        if (cmd.finish) begin
            valid_next = 1'b1;
            duty_next  = q_reg;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        x0_reg   <= x0_next;
        x1_reg   <= x1_next;
        y0_reg   <= y0_next;
        y1_reg   <= y1_next;
        num_reg  <= num_next;
        dvs_reg  <= dvs_next;
        q_reg    <= q_next;
        duty_reg <= duty_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            flag_reg  <= flag_next;
            valid_reg <= valid_next;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_reg  <= scpwm_pkg::FULL_ON_RST;
            off_reg <= scpwm_pkg::FULL_OFF_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_addr)
                scpwm_pkg::REG_FULL_ON:  on_reg  <= cfg_wr_data;
                scpwm_pkg::REG_FULL_OFF: off_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign status.direct    = direct;
    assign status.out_busy  = valid_reg & ~m_tready;
    assign status.on_level  = on_reg;
    assign status.off_level = off_reg;
    assign m_tvalid         = valid_reg;
    assign duty_out         = duty_reg;
    assign flag_out         = flag_reg;

endmodule

`default_nettype wire

/* rtl/core/scpwm_ctrl.sv */
// Per-sample FSM: segment, two products and divide unless direct, then finish.
`timescale 1ns / 1ps
`default_nettype none

module scpwm_ctrl (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire scpwm_pkg::dp_status_t   status,
    output scpwm_pkg::dp_cmd_t           cmd
);

    localparam int CNT_W = $clog2(scpwm_pkg::DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(scpwm_pkg::DIV_STEPS - 1);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SEG  = 6'b000010,
        ST_MUL0 = 6'b000100,
        ST_MUL1 = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SEG;
                end
            end
            ST_SEG: begin
                cmd.seg    = 1'b1;
                state_next = status.direct ? ST_FIN : ST_MUL0;
            end
            ST_MUL0: begin
                cmd.mul0   = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.mul1   = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                // Hold until the output register frees up
                if (!status.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/sensor_curve_pwm_with_hysteresis.sv */
// After the input transaction a sample passes through the segment, product, 10-step divide and
// finish states, or from segment to finish on a clamp or breakpoint hit; one sample at a time.
// The shared multiplier serves both product states; a full output register stalls the finish step.
// Reset: aresetn synchronous, active low; clears the state machine, output valid, full-power
// flag, and sets full_on_level to 0 and full_off_level to 3.
`timescale 1ns / 1ps
`default_nettype none
`include "sensor_curve_pwm_with_hysteresis_macros.svh"

module sensor_curve_pwm_with_hysteresis #(
    parameter int NUM_POINTS = scpwm_pkg::NUM_POINTS_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire [scpwm_pkg::S_TDATA_W-1:0]      s_tdata,    // [11:0] hall_sample
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [scpwm_pkg::M_TDATA_W-1:0]     m_tdata,    // [9:0] pwm_duty, [10] full_power
    input  wire                                 cfg_wr_en,
    input  wire [scpwm_pkg::CFG_ADDR_W-1:0]     cfg_wr_addr,
    input  wire [scpwm_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    scpwm_pkg::dp_cmd_t              cmd;
    scpwm_pkg::dp_status_t           status;
    logic [scpwm_pkg::DUTY_W-1:0]    duty_out;
    logic                            flag_out;

    scpwm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    scpwm_datapath #(
        .NUM_POINTS (NUM_POINTS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .sample_in   (s_tdata[scpwm_pkg::SAMPLE_W-1:0]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_addr (cfg_wr_addr),
        .cfg_wr_data (cfg_wr_data),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .duty_out    (duty_out),
        .flag_out    (flag_out)
    );

    // Pack result: duty low, flag above, zero fill
    assign m_tdata = {{(scpwm_pkg::M_TDATA_W - scpwm_pkg::DUTY_W - 1){1'b0}}, flag_out, duty_out};

    // One sample in flight: no second accept right after a transaction
    `SCPWM_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // Duty above the off level must show full power off
    `SCPWM_ASSERT_SAME(a_flag_clear, aclk, aresetn, m_tvalid && (duty_out > status.off_level),
        !flag_out)
    // Duty at or below both levels must show full power on
    `SCPWM_ASSERT_SAME(a_flag_set, aclk, aresetn,
        m_tvalid && (duty_out <= status.on_level) && (duty_out <= status.off_level), flag_out)

endmodule

`default_nettype wire
